### hdl/rsw_pkg.sv
// Shared widths and pipeline depths for the RSW frame projection core.
package rsw_pkg;

  localparam int POS_W = 40;
  localparam int VEL_W = 24;
  localparam int COR_W = 32;
  localparam int RES_W = 32;

  // 4*d^2 numerator, squared-length denominator, quotient and root widths
  localparam int NW  = 194;
  localparam int DW  = 128;
  localparam int QW  = 64;
  localparam int RW  = QW / 2;
  localparam int SRW = RW + 2;

  localparam int PRE_ST   = 6;
  localparam int LANE_LAT = QW + RW + 2;
  localparam int TOP_LAT  = PRE_ST + LANE_LAT;

endpackage

### hdl/rsw_proj_lane.sv
// One projection lane: restoring divide, digit-by-digit root, round and saturate.
module rsw_proj_lane import rsw_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NW-1:0]    num_i,
  input  logic [DW-1:0]    den_i,
  input  logic             neg_i,
  output logic [RES_W-1:0] res_o
);

  localparam logic [RW:0]      CAP_N   = (RW+1)'(1) << (RES_W - 1);
  localparam logic [RES_W-1:0] SAT_POS = {1'b0, {(RES_W-1){1'b1}}};

  // divider stages
  logic [DW-1:0] rem_q [QW+1];
  logic [DW-1:0] den_q [QW+1];
  logic [QW-1:0] low_q [QW+1];
  logic          neg_q [QW+1];
  logic          sat_q [QW+1];
  logic [DW:0]   trl_s [QW];
  logic          dge_s [QW];
  logic [DW-1:0] rem_d [QW];
  logic [QW-1:0] low_d [QW];

  // root stages
  logic [QW-1:0]  sqv_q [RW];
  logic [SRW-1:0] srm_q [RW];
  logic [RW-1:0]  rot_q [RW];
  logic           sng_q [RW];
  logic           sst_q [RW];
  logic [QW-1:0]  src_qv  [RW];
  logic [SRW-1:0] src_rem [RW];
  logic [RW-1:0]  src_rot [RW];
  logic           src_neg [RW];
  logic           src_sat [RW];
  logic [SRW+1:0] r2_s [RW];
  logic [SRW+1:0] tr_s [RW];
  logic           sge_s [RW];

  logic [RW:0]      n_s;
  logic [RES_W-1:0] res_d;
  logic [RES_W-1:0] res_q;

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      trl_s[k] = {rem_q[k], low_q[k][QW-1]};
      dge_s[k] = trl_s[k] >= {1'b0, den_q[k]};
      rem_d[k] = dge_s[k] ? DW'(trl_s[k] - {1'b0, den_q[k]}) : trl_s[k][DW-1:0];
      low_d[k] = {low_q[k][QW-2:0], dge_s[k]};
    end
  end

  always_comb begin
    src_qv[0]  = low_q[QW];
    src_rem[0] = '0;
    src_rot[0] = '0;
    src_neg[0] = neg_q[QW];
    src_sat[0] = sat_q[QW];
    for (int k = 1; k < RW; k++) begin
      src_qv[k]  = sqv_q[k-1];
      src_rem[k] = srm_q[k-1];
      src_rot[k] = rot_q[k-1];
      src_neg[k] = sng_q[k-1];
      src_sat[k] = sst_q[k-1];
    end
    for (int k = 0; k < RW; k++) begin
      r2_s[k]  = {src_rem[k], src_qv[k][QW-1:QW-2]};
      tr_s[k]  = {2'b00, src_rot[k], 2'b01};
      sge_s[k] = r2_s[k] >= tr_s[k];
    end
  end

  // round half up on the odd bound, then apply sign and saturate
  always_comb begin
    n_s = ((RW+1)'(rot_q[RW-1]) + (RW+1)'(1)) >> 1;
    if (sst_q[RW-1]) n_s = CAP_N;
    if (sng_q[RW-1]) begin
      res_d = RES_W'(-n_s);
    end else if (n_s[RES_W-1]) begin
      res_d = SAT_POS;
    end else begin
      res_d = n_s[RES_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i[QW+DW-1:QW];
      low_q[0] <= num_i[QW-1:0];
      den_q[0] <= den_i;
      neg_q[0] <= neg_i;
      sat_q[0] <= num_i[NW-1:QW] >= (NW-QW)'(den_i);
      for (int k = 0; k < QW; k++) begin
        rem_q[k+1] <= rem_d[k];
        low_q[k+1] <= low_d[k];
        den_q[k+1] <= den_q[k];
        neg_q[k+1] <= neg_q[k];
        sat_q[k+1] <= sat_q[k];
      end
      for (int k = 0; k < RW; k++) begin
        sqv_q[k] <= {src_qv[k][QW-3:0], 2'b00};
        srm_q[k] <= sge_s[k] ? SRW'(r2_s[k] - tr_s[k]) : r2_s[k][SRW-1:0];
        rot_q[k] <= {src_rot[k][RW-2:0], sge_s[k]};
        sng_q[k] <= src_neg[k];
        sst_q[k] <= src_sat[k];
      end
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### hdl/rsw_frame_projection_core.sv
// Top level of the RSW frame projection core.
// Projects a correction vector onto the radial, along-track and cross-track
// directions of a position/velocity pair and rounds each component to the
// nearest millimetre, halves away from zero, saturated to 32 bits. One beat
// is taken every cycle while the output is not stalled.
// The depth is six stages of products and sums, then per component a
// 64-stage restoring divider and a 32-stage square root. A stalled output
// holds the whole pipeline; a zero-length axis gives zeros with degenerate set.
module rsw_frame_projection_core import rsw_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [POS_W-1:0] pos_x_i,
  input  logic signed [POS_W-1:0] pos_y_i,
  input  logic signed [POS_W-1:0] pos_z_i,
  input  logic signed [VEL_W-1:0] vel_x_i,
  input  logic signed [VEL_W-1:0] vel_y_i,
  input  logic signed [VEL_W-1:0] vel_z_i,
  input  logic signed [COR_W-1:0] corr_x_i,
  input  logic signed [COR_W-1:0] corr_y_i,
  input  logic signed [COR_W-1:0] corr_z_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [RES_W-1:0] radial_o,
  output logic signed [RES_W-1:0] along_o,
  output logic signed [RES_W-1:0] out_of_plane_o,
  output logic                    degenerate_o
);

  typedef struct packed {
    logic vld;
    logic degen;
  } side_t;

  logic en;
  side_t side_q [TOP_LAT];

  logic signed [POS_W-1:0] pos_s [3];
  logic signed [VEL_W-1:0] vel_s [3];
  logic signed [COR_W-1:0] cor_s [3];

  // stage 1: products
  logic signed [63:0] rv_q [6];
  logic [78:0]        rr_q [3];
  logic [46:0]        vv_q [3];
  logic signed [71:0] cr_q [3];
  logic signed [55:0] cv_q [3];
  logic signed [31:0] c1_q [3];
  logic signed [79:0] rr_s [3];
  logic signed [47:0] vv_s [3];

  // stage 2: cross product, lengths, dot products
  logic signed [63:0] h_q [3];
  logic [80:0]        sr2_q;
  logic [48:0]        sv2_q;
  logic signed [73:0] dr_q;
  logic signed [57:0] dv_q;
  logic signed [31:0] c2_q [3];

  // stage 3: split products
  logic signed [63:0] chh_q [3];
  logic signed [64:0] chl_q [3];
  logic [63:0]        hhh_q [3];
  logic [63:0]        hhl_q [3];
  logic [63:0]        hll_q [3];
  logic [71:0]        drhh_q, drhl_q, drll_q;
  logic [55:0]        dvhh_q, dvhl_q, dvll_q;
  logic [80:0]        sr3_q;
  logic [48:0]        sv3_q;
  logic               drn3_q, dvn3_q;
  logic [63:0]        ha_s [3];
  logic [71:0]        dra_s;
  logic [55:0]        dva_s;

  // stage 4: sums
  logic signed [97:0] dh_q;
  logic [DW-1:0]      sh4_q;
  logic [143:0]       dr24_q;
  logic [111:0]       dv24_q;
  logic [80:0]        sr4_q;
  logic [48:0]        sv4_q;
  logic               drn4_q, dvn4_q;

  // stage 5: square of the cross-track dot product, in limbs
  logic [63:0]        p00_q, p11_q, p22_q, p01_q, p02_q, p12_q;
  logic [95:0]        dha_s;
  logic [DW-1:0]      sh5_q;
  logic [143:0]       dr25_q;
  logic [111:0]       dv25_q;
  logic [80:0]        sr5_q;
  logic [48:0]        sv5_q;
  logic               drn5_q, dvn5_q, dhn5_q;

  // stage 6: lane operands
  logic [191:0]       dh26_q;
  logic [DW-1:0]      sh6_q;
  logic [143:0]       dr26_q;
  logic [111:0]       dv26_q;
  logic [80:0]        sr6_q;
  logic [48:0]        sv6_q;
  logic               drn6_q, dvn6_q, dhn6_q;

  logic [RES_W-1:0]   rad_s, alo_s, oop_s;

  assign pos_s[0] = pos_x_i;
  assign pos_s[1] = pos_y_i;
  assign pos_s[2] = pos_z_i;
  assign vel_s[0] = vel_x_i;
  assign vel_s[1] = vel_y_i;
  assign vel_s[2] = vel_z_i;
  assign cor_s[0] = corr_x_i;
  assign cor_s[1] = corr_y_i;
  assign cor_s[2] = corr_z_i;

  // advance whenever the output register is free or being taken
  assign en          = out_ready_i | ~side_q[TOP_LAT-1].vld;
  assign in_ready_o  = en;
  assign out_valid_o = side_q[TOP_LAT-1].vld;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TOP_LAT; k++) side_q[k] <= '0;
    end else if (en) begin
      side_q[0] <= '{vld: in_valid_i, degen: 1'b0};
      for (int k = 1; k < TOP_LAT; k++) begin
        if (k != 4) side_q[k] <= side_q[k-1];
      end
      side_q[4] <= '{vld: side_q[3].vld,
                     degen: (sr4_q == '0) | (sv4_q == '0) | (sh4_q == '0)};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rr_s[i] = 80'(pos_s[i]) * 80'(pos_s[i]);
      vv_s[i] = 48'(vel_s[i]) * 48'(vel_s[i]);
      ha_s[i] = h_q[i][63] ? 64'(-h_q[i]) : 64'(h_q[i]);
    end
    dra_s = dr_q[73] ? 72'(-dr_q) : 72'(dr_q);
    dva_s = dv_q[57] ? 56'(-dv_q) : 56'(dv_q);
    dha_s = dh_q[97] ? 96'(-dh_q) : 96'(dh_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1
      rv_q[0] <= 64'(pos_s[1]) * 64'(vel_s[2]);
      rv_q[1] <= 64'(pos_s[2]) * 64'(vel_s[1]);
      rv_q[2] <= 64'(pos_s[2]) * 64'(vel_s[0]);
      rv_q[3] <= 64'(pos_s[0]) * 64'(vel_s[2]);
      rv_q[4] <= 64'(pos_s[0]) * 64'(vel_s[1]);
      rv_q[5] <= 64'(pos_s[1]) * 64'(vel_s[0]);
      for (int i = 0; i < 3; i++) begin
        rr_q[i] <= rr_s[i][78:0];
        vv_q[i] <= vv_s[i][46:0];
        cr_q[i] <= 72'(cor_s[i]) * 72'(pos_s[i]);
        cv_q[i] <= 56'(cor_s[i]) * 56'(vel_s[i]);
        c1_q[i] <= cor_s[i];
      end
      // stage 2
      h_q[0] <= rv_q[0] - rv_q[1];
      h_q[1] <= rv_q[2] - rv_q[3];
      h_q[2] <= rv_q[4] - rv_q[5];
      sr2_q  <= 81'(rr_q[0]) + 81'(rr_q[1]) + 81'(rr_q[2]);
      sv2_q  <= 49'(vv_q[0]) + 49'(vv_q[1]) + 49'(vv_q[2]);
      dr_q   <= 74'(cr_q[0]) + 74'(cr_q[1]) + 74'(cr_q[2]);
      dv_q   <= 58'(cv_q[0]) + 58'(cv_q[1]) + 58'(cv_q[2]);
      c2_q   <= c1_q;
      // stage 3
      for (int i = 0; i < 3; i++) begin
        chh_q[i] <= 64'(c2_q[i]) * 64'($signed(h_q[i][63:32]));
        chl_q[i] <= 65'(c2_q[i]) * 65'($signed({1'b0, h_q[i][31:0]}));
        hhh_q[i] <= 64'(ha_s[i][63:32]) * 64'(ha_s[i][63:32]);
        hhl_q[i] <= 64'(ha_s[i][63:32]) * 64'(ha_s[i][31:0]);
        hll_q[i] <= 64'(ha_s[i][31:0]) * 64'(ha_s[i][31:0]);
      end
      drhh_q <= 72'(dra_s[71:36]) * 72'(dra_s[71:36]);
      drhl_q <= 72'(dra_s[71:36]) * 72'(dra_s[35:0]);
      drll_q <= 72'(dra_s[35:0]) * 72'(dra_s[35:0]);
      dvhh_q <= 56'(dva_s[55:28]) * 56'(dva_s[55:28]);
      dvhl_q <= 56'(dva_s[55:28]) * 56'(dva_s[27:0]);
      dvll_q <= 56'(dva_s[27:0]) * 56'(dva_s[27:0]);
      sr3_q  <= sr2_q;
      sv3_q  <= sv2_q;
      drn3_q <= dr_q[73];
      dvn3_q <= dv_q[57];
      // stage 4
      dh_q <= (98'(chh_q[0]) <<< 32) + 98'(chl_q[0])
            + (98'(chh_q[1]) <<< 32) + 98'(chl_q[1])
            + (98'(chh_q[2]) <<< 32) + 98'(chl_q[2]);
      sh4_q <= (DW'(hhh_q[0]) << 64) + (DW'(hhl_q[0]) << 33) + DW'(hll_q[0])
             + (DW'(hhh_q[1]) << 64) + (DW'(hhl_q[1]) << 33) + DW'(hll_q[1])
             + (DW'(hhh_q[2]) << 64) + (DW'(hhl_q[2]) << 33) + DW'(hll_q[2]);
      dr24_q <= (144'(drhh_q) << 72) + (144'(drhl_q) << 37) + 144'(drll_q);
      dv24_q <= (112'(dvhh_q) << 56) + (112'(dvhl_q) << 29) + 112'(dvll_q);
      sr4_q  <= sr3_q;
      sv4_q  <= sv3_q;
      drn4_q <= drn3_q;
      dvn4_q <= dvn3_q;
      // stage 5
      p00_q  <= 64'(dha_s[31:0])  * 64'(dha_s[31:0]);
      p11_q  <= 64'(dha_s[63:32]) * 64'(dha_s[63:32]);
      p22_q  <= 64'(dha_s[95:64]) * 64'(dha_s[95:64]);
      p01_q  <= 64'(dha_s[31:0])  * 64'(dha_s[63:32]);
      p02_q  <= 64'(dha_s[31:0])  * 64'(dha_s[95:64]);
      p12_q  <= 64'(dha_s[63:32]) * 64'(dha_s[95:64]);
      dhn5_q <= dh_q[97];
      sh5_q  <= sh4_q;
      dr25_q <= dr24_q;
      dv25_q <= dv24_q;
      sr5_q  <= sr4_q;
      sv5_q  <= sv4_q;
      drn5_q <= drn4_q;
      dvn5_q <= dvn4_q;
      // stage 6
      dh26_q <= (192'(p22_q) << 128) + (192'(p11_q) << 64) + 192'(p00_q)
              + (192'(p01_q) << 33) + (192'(p02_q) << 65) + (192'(p12_q) << 97);
      dhn6_q <= dhn5_q;
      sh6_q  <= sh5_q;
      dr26_q <= dr25_q;
      dv26_q <= dv25_q;
      sr6_q  <= sr5_q;
      sv6_q  <= sv5_q;
      drn6_q <= drn5_q;
      dvn6_q <= dvn5_q;
    end
  end

  rsw_proj_lane u_rad (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (NW'({dr26_q, 2'b00})),
    .den_i (DW'(sr6_q)),
    .neg_i (drn6_q),
    .res_o (rad_s)
  );

  rsw_proj_lane u_alo (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (NW'({dv26_q, 2'b00})),
    .den_i (DW'(sv6_q)),
    .neg_i (dvn6_q),
    .res_o (alo_s)
  );

  rsw_proj_lane u_oop (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (NW'({dh26_q, 2'b00})),
    .den_i (sh6_q),
    .neg_i (dhn6_q),
    .res_o (oop_s)
  );

  // force zeros on a degenerate frame
  assign degenerate_o   = side_q[TOP_LAT-1].degen;
  assign radial_o       = degenerate_o ? '0 : $signed(rad_s);
  assign along_o        = degenerate_o ? '0 : $signed(alo_s);
  assign out_of_plane_o = degenerate_o ? '0 : $signed(oop_s);

endmodule

### verif/tb.sv
// Testbench for rsw_frame_projection_core: directed table, then random beats checked in order.
`timescale 1ns / 1ps

module tb;
  import rsw_pkg::*;

  localparam int NUM_RANDOM = 1130;
  localparam int MAX_SHOWN  = 10;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic signed [POS_W-1:0] pos [3];
    logic signed [VEL_W-1:0] vel [3];
    logic signed [COR_W-1:0] corr [3];
  } vec_beat_t;

  typedef struct packed {
    logic signed [RES_W-1:0] radial;
    logic signed [RES_W-1:0] along;
    logic signed [RES_W-1:0] out_of_plane;
    logic                    degenerate;
  } rsw_t;

  typedef struct {
    vec_beat_t beat;
    bit        typed;
    rsw_t      res;
  } stim_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [POS_W-1:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [VEL_W-1:0] vel_x_i, vel_y_i, vel_z_i;
  logic signed [COR_W-1:0] corr_x_i, corr_y_i, corr_z_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic signed [RES_W-1:0] radial_o, along_o, out_of_plane_o;
  logic                    degenerate_o;

  rsw_t      rsw_expected_q[$];
  stim_row_t stim_table[$];
  int        mismatches;
  int        beats_in, beats_out, degenerate_seen, saturated_seen;
  bit        stim_done;
  bit        no_idle;

  rsw_frame_projection_core DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d beats in, %0d results out, %0d pending",
             beats_in, beats_out, rsw_expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // round(|d| / sqrt(s)) with sign restored, halves away from zero, saturated
  function automatic logic [RES_W-1:0] round_projection(wide_t d, logic [255:0] s);
    logic        neg;
    logic [255:0] mag, num, lhs;
    logic [63:0] lo, hi, mid, k;
    neg = d[255];
    mag = neg ? -d : d;
    num = mag * mag * 256'd4;
    lo  = 64'd0;
    hi  = 64'd1 << 31;
    while (lo < hi) begin
      mid = lo + (hi - lo + 64'd1) / 64'd2;
      k   = 64'd2 * mid - 64'd1;
      lhs = 256'(k * k) * s;
      if (lhs <= num) lo = mid;
      else hi = mid - 64'd1;
    end
    if (neg) return RES_W'(64'd0 - lo);
    if (lo > 64'h7FFF_FFFF) lo = 64'h7FFF_FFFF;
    return RES_W'(lo);
  endfunction

  function automatic rsw_t project_rsw(vec_beat_t b);
    wide_t r[3], v[3], c[3], h[3];
    wide_t sr, sv, sh;
    rsw_t  o;
    for (int i = 0; i < 3; i++) begin
      r[i] = b.pos[i];
      v[i] = b.vel[i];
      c[i] = b.corr[i];
    end
    h[0] = r[1] * v[2] - r[2] * v[1];
    h[1] = r[2] * v[0] - r[0] * v[2];
    h[2] = r[0] * v[1] - r[1] * v[0];
    sr = r[0] * r[0] + r[1] * r[1] + r[2] * r[2];
    sv = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    sh = h[0] * h[0] + h[1] * h[1] + h[2] * h[2];
    o = '{default: '0};
    if (sr == 0 || sv == 0 || sh == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    o.radial       = round_projection(c[0] * r[0] + c[1] * r[1] + c[2] * r[2], sr);
    o.along        = round_projection(c[0] * v[0] + c[1] * v[1] + c[2] * v[2], sv);
    o.out_of_plane = round_projection(c[0] * h[0] + c[1] * h[1] + c[2] * h[2], sh);
    return o;
  endfunction

  function automatic vec_beat_t make_beat(longint px, longint py, longint pz,
                                          longint vx, longint vy, longint vz,
                                          longint cx, longint cy, longint cz);
    vec_beat_t b;
    b.pos  = '{POS_W'(px), POS_W'(py), POS_W'(pz)};
    b.vel  = '{VEL_W'(vx), VEL_W'(vy), VEL_W'(vz)};
    b.corr = '{COR_W'(cx), COR_W'(cy), COR_W'(cz)};
    return b;
  endfunction

  task automatic add_row(vec_beat_t b, bit typed, longint rad = 0, longint alg = 0,
                         longint oop = 0, bit deg = 0);
    stim_row_t row;
    row.beat  = b;
    row.typed = typed;
    row.res   = '{radial: RES_W'(rad), along: RES_W'(alg), out_of_plane: RES_W'(oop),
                  degenerate: deg};
    stim_table.push_back(row);
  endtask

  function automatic logic [63:0] draw_field(int mode, int width);
    logic [63:0] val;
    case (mode)
      0: val = {$urandom, $urandom};
      1: val = 64'($signed($urandom_range(0, 4000)) - 2000);
      2: val = $urandom_range(0, 1) ? (64'd1 << (width - 1)) : ~(64'd1 << (width - 1));
      default: val = $urandom_range(0, 3) == 0 ? 64'd0 : {$urandom, $urandom};
    endcase
    return val;
  endfunction

  function automatic vec_beat_t random_beat();
    vec_beat_t b;
    int m;
    m = $urandom_range(0, 9);
    for (int i = 0; i < 3; i++) begin
      b.pos[i]  = POS_W'(draw_field(m < 5 ? 0 : m < 7 ? 1 : m < 8 ? 2 : 3, POS_W));
      b.vel[i]  = VEL_W'(draw_field(m < 5 ? 0 : m < 7 ? 1 : m < 8 ? 2 : 3, VEL_W));
      b.corr[i] = COR_W'(draw_field($urandom_range(0, 3), COR_W));
    end
    // sometimes make velocity parallel to position so the cross axis vanishes
    if ($urandom_range(0, 39) == 0) begin
      b.pos = '{POS_W'(b.vel[0]) * 3, POS_W'(b.vel[1]) * 3, POS_W'(b.vel[2]) * 3};
    end
    return b;
  endfunction

  task automatic send_beat(vec_beat_t b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {pos_x_i, pos_y_i, pos_z_i}    <= {b.pos[0], b.pos[1], b.pos[2]};
    {vel_x_i, vel_y_i, vel_z_i}    <= {b.vel[0], b.vel[1], b.vel[2]};
    {corr_x_i, corr_y_i, corr_z_i} <= {b.corr[0], b.corr[1], b.corr[2]};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // record each accepted input beat and check each accepted result beat
  always @(posedge clk_i) begin
    vec_beat_t b;
    rsw_t      got, want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      b.pos  = '{pos_x_i, pos_y_i, pos_z_i};
      b.vel  = '{vel_x_i, vel_y_i, vel_z_i};
      b.corr = '{corr_x_i, corr_y_i, corr_z_i};
      rsw_expected_q.push_back(project_rsw(b));
      beats_in++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{radial_o, along_o, out_of_plane_o, degenerate_o};
      beats_out++;
      if (degenerate_o) degenerate_seen++;
      if (radial_o == 32'h7FFF_FFFF || radial_o == 32'h8000_0000) saturated_seen++;
      if (rsw_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("Unexpected result beat %0d: rad %0d alg %0d oop %0d deg %0b",
                   beats_out, radial_o, along_o, out_of_plane_o, degenerate_o);
      end else begin
        want = rsw_expected_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("Mismatch beat %0d: exp rad %0d alg %0d oop %0d deg %0b, got rad %0d alg %0d oop %0d deg %0b",
                     beats_out, want.radial, want.along, want.out_of_plane, want.degenerate,
                     got.radial, got.along, got.out_of_plane, got.degenerate);
        end
      end
    end
  end

  // result side: hold off ready at random before each beat, except in idle-free bursts
  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    localparam longint PMAX = (64'sd1 <<< (POS_W - 1)) - 1;
    localparam longint PMIN = -(64'sd1 <<< (POS_W - 1));
    localparam longint VMAX = (64'sd1 <<< (VEL_W - 1)) - 1;
    localparam longint VMIN = -(64'sd1 <<< (VEL_W - 1));
    localparam longint CMAX = 64'sd2147483647;
    localparam longint CMIN = -64'sd2147483648;
    rsw_t pred;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    {pos_x_i, pos_y_i, pos_z_i}    = '0;
    {vel_x_i, vel_y_i, vel_z_i}    = '0;
    {corr_x_i, corr_y_i, corr_z_i} = '0;
    mismatches = 0;
    no_idle    = 1'b0;
    stim_done  = 1'b0;

    // zero-length axes
    add_row(make_beat(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, 1);
    add_row(make_beat(0, 0, 0, 5, 6, 7, 100, 200, 300), 1, 0, 0, 0, 1);
    add_row(make_beat(1000, 2000, 3000, 0, 0, 0, 1, 2, 3), 1, 0, 0, 0, 1);
    add_row(make_beat(200, -400, 600, -1, 2, -3, 9, 9, 9), 1, 0, 0, 0, 1);
    // orthogonal coordinate axes give each correction component, negated and saturated where an axis points negative
    add_row(make_beat(1000, 0, 0, 0, 1000, 0, 5, 7, -9), 1, 5, 7, -9);
    add_row(make_beat(-1000, 0, 0, 0, -1000, 0, 5, 7, -9), 1, -5, -7, -9);
    add_row(make_beat(PMAX, 0, 0, 0, VMAX, 0, CMIN, CMAX, CMIN), 1, CMIN, CMAX, CMIN);
    add_row(make_beat(PMIN, 0, 0, 0, VMIN, 0, CMAX, CMIN, CMAX), 1, -CMAX, CMAX, CMAX);
    add_row(make_beat(0, 0, PMIN, VMIN, 0, 0, CMIN, CMIN, CMIN), 1, CMAX, CMAX, CMIN);
    // saturation both ways
    add_row(make_beat(1, 1, 1, 1, -1, 0, CMAX, CMAX, CMAX), 1, CMAX, 0, 0);
    add_row(make_beat(1, 1, 1, 1, -1, 0, CMIN, CMIN, CMIN), 1, CMIN, 0, 0);
    // rounding near halves and mixed extremes
    add_row(make_beat(1, 1, 0, 0, 0, 1, 1, 0, 0), 1, 1, 0, 1);
    add_row(make_beat(2, 1, 2, 1, 0, 0, 1, 0, 0), 0);
    add_row(make_beat(3, 4, 0, -4, 3, 0, 7, 2, 5), 0);
    add_row(make_beat(PMAX, PMAX, PMAX, VMIN, VMAX, 0, CMAX, CMIN, CMAX), 0);
    add_row(make_beat(PMIN, PMIN, PMAX, VMIN, VMIN, VMAX, CMIN, CMIN, CMIN), 0);
    add_row(make_beat(PMAX, PMIN, 1, VMAX, VMAX, VMIN, -1, -1, -1), 0);
    add_row(make_beat(-1, -1, -1, -1, 1, 0, 1, 1, 1), 0);
    add_row(make_beat(7000000, -3, 12, 1, 7000, -5, 3, -3, 2), 0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      if (stim_table[i].typed) begin
        pred = project_rsw(stim_table[i].beat);
        if (pred != stim_table[i].res) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("Directed row %0d: table rad %0d alg %0d oop %0d deg %0b, predicted rad %0d alg %0d oop %0d deg %0b",
                     i, stim_table[i].res.radial, stim_table[i].res.along,
                     stim_table[i].res.out_of_plane, stim_table[i].res.degenerate,
                     pred.radial, pred.along, pred.out_of_plane, pred.degenerate);
        end
      end
      send_beat(stim_table[i].beat);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (n == NUM_RANDOM / 2) begin
        // hold off until the pipeline has drained
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (rsw_expected_q.size() != 0) @(posedge clk_i);
      end
      send_beat(random_beat());
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;

    while (rsw_expected_q.size() != 0) @(posedge clk_i);
    repeat (TOP_LAT + 20) @(posedge clk_i);

    $display("Covered %0d beats in, %0d results out, %0d degenerate, %0d radial saturated,",
             beats_in, beats_out, degenerate_seen, saturated_seen);
    $display("with random gaps and stalls, idle-free bursts and one full drain midway.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
